@@ hw/rtl/vns_pkg.sv @@
// Shared constants and types for the 2D value-noise sampler.
// No dependencies; imported by every module of the block.
package vns_pkg;

   localparam int COORD_W            = 32;
   localparam int PERIOD_W           = 9;
   localparam int NOISE_W            = 16;
   localparam int DEF_MAX_PERIOD     = 256;
   localparam int DEF_FRACTION_BITS  = 16;
   localparam int DIV_BITS_PER_STAGE = 4;

   typedef logic [31:0] hash_word_type;

   localparam hash_word_type HASH_MUL_X = 32'h9e3779b9;
   localparam hash_word_type HASH_MUL_Z = 32'h85ebca6b;
   localparam hash_word_type HASH_MIX_A = 32'h7feb352d;
   localparam hash_word_type HASH_MIX_B = 32'h846ca68b;

endpackage

@@ hw/rtl/vns_split.sv @@
// Pipelined floor division of both coordinates by the period.
// Gives cell index and Q0.F offset fraction per axis. Uses vns_pkg.
module vns_split #(
   parameter int MAX_PERIOD = 256,
   parameter int FRAC_W     = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           adv,
   input  logic                           in_valid,
   input  logic signed [vns_pkg::COORD_W-1:0] coord_x,
   input  logic signed [vns_pkg::COORD_W-1:0] coord_z,
   input  logic [vns_pkg::PERIOD_W-1:0]   period,
   input  vns_pkg::hash_word_type         key,
   output logic                           out_valid,
   output vns_pkg::hash_word_type         cell_x,
   output vns_pkg::hash_word_type         cell_z,
   output logic [FRAC_W-1:0]              frac_x,
   output logic [FRAC_W-1:0]              frac_z,
   output vns_pkg::hash_word_type         out_key
);
   import vns_pkg::*;

   // (coord << F) is never below -2^(31+F); its ones' complement fits DW bits
   localparam int DW  = COORD_W + FRAC_W - 1;
   localparam int BPS = DIV_BITS_PER_STAGE;
   localparam int NS  = (DW + BPS - 1) / BPS;

   logic [DW-1:0]       num_ff [NS+1][2];
   logic [DW-1:0]       num_in [NS+1][2];
   logic [PERIOD_W-1:0] rem_ff [NS+1][2];
   logic [PERIOD_W-1:0] rem_in [NS+1][2];
   logic [1:0]          neg_ff [NS+1];
   logic [1:0]          neg_in [NS+1];
   logic [PERIOD_W-1:0] div_ff [NS+1];
   logic [PERIOD_W-1:0] div_in [NS+1];
   hash_word_type       key_ff [NS+1];
   hash_word_type       key_in [NS+1];
   logic [NS:0]         vld_ff;

   always_comb begin
      logic [COORD_W+FRAC_W-1:0] shifted;
      logic [DW-1:0]             n;
      logic [PERIOD_W:0]         r2;
      logic [PERIOD_W-1:0]       r;
      logic [PERIOD_W-1:0]       p;

      // entry stage: clamp period, fold negatives onto ones' complement
      if (period == '0) begin
         p = PERIOD_W'(1);
      end else if (32'(period) > 32'(MAX_PERIOD)) begin
         p = PERIOD_W'(MAX_PERIOD);
      end else begin
         p = period;
      end
      div_in[0] = p;
      key_in[0] = key;
      neg_in[0] = {coord_z[COORD_W-1], coord_x[COORD_W-1]};
      shifted = {coord_x, {FRAC_W{1'b0}}};
      num_in[0][0] = coord_x[COORD_W-1] ? ~shifted[DW-1:0] : shifted[DW-1:0];
      shifted = {coord_z, {FRAC_W{1'b0}}};
      num_in[0][1] = coord_z[COORD_W-1] ? ~shifted[DW-1:0] : shifted[DW-1:0];
      rem_in[0][0] = '0;
      rem_in[0][1] = '0;

      // restoring division, BPS quotient bits per stage
      for (int s = 0; s < NS; s++) begin
         div_in[s+1] = div_ff[s];
         key_in[s+1] = key_ff[s];
         neg_in[s+1] = neg_ff[s];
         for (int l = 0; l < 2; l++) begin
            n = num_ff[s][l];
            r = rem_ff[s][l];
            for (int k = 0; k < BPS; k++) begin
               if (s * BPS + k < DW) begin
                  r2 = {r, n[DW-1]};
                  n  = {n[DW-2:0], 1'b0};
                  if (r2 >= {1'b0, div_ff[s]}) begin
                     r2   = r2 - {1'b0, div_ff[s]};
                     n[0] = 1'b1;
                  end
                  r = r2[PERIOD_W-1:0];
               end
            end
            num_in[s+1][l] = n;
            rem_in[s+1][l] = r;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NS-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         num_ff <= num_in;
         rem_ff <= rem_in;
         neg_ff <= neg_in;
         div_ff <= div_in;
         key_ff <= key_in;
      end
   end

   // undo the complement: floor(n/p) = ~floor(~n/p) for negative n
   always_comb begin
      logic [COORD_W+FRAC_W-1:0] qx;
      logic [COORD_W+FRAC_W-1:0] qz;
      qx = {1'b0, num_ff[NS][0]};
      qz = {1'b0, num_ff[NS][1]};
      if (neg_ff[NS][0]) qx = ~qx;
      if (neg_ff[NS][1]) qz = ~qz;
      cell_x = qx[COORD_W+FRAC_W-1:FRAC_W];
      cell_z = qz[COORD_W+FRAC_W-1:FRAC_W];
      frac_x = qx[FRAC_W-1:0];
      frac_z = qz[FRAC_W-1:0];
   end

   assign out_valid = vld_ff[NS];
   assign out_key   = key_ff[NS];

endmodule

@@ hw/rtl/vns_hash.sv @@
// Corner hash pipeline (four corners) with smoothstep easing alongside.
// Five register stages. Uses vns_pkg.
module vns_hash #(
   parameter int FRAC_W = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  vns_pkg::hash_word_type        cell_x,
   input  vns_pkg::hash_word_type        cell_z,
   input  logic [FRAC_W-1:0]             frac_x,
   input  logic [FRAC_W-1:0]             frac_z,
   input  vns_pkg::hash_word_type        key,
   output logic                          out_valid,
   output logic [vns_pkg::NOISE_W-1:0]   corner [4],
   output logic [FRAC_W-1:0]             ease_x,
   output logic [FRAC_W-1:0]             ease_z
);
   import vns_pkg::*;

   localparam int W2 = 2 * FRAC_W;
   localparam int W3 = 2 * FRAC_W + 2;

   logic [4:0]       vld_ff;
   // stage 1
   hash_word_type    mx_ff, mz_ff, key_ff;
   logic [FRAC_W-1:0] tx_ff, tz_ff, ux_ff, uz_ff;
   // stage 2
   hash_word_type    h2_ff [4];
   hash_word_type    h2_in [4];
   // stage 3..5
   hash_word_type    h3_ff [4];
   hash_word_type    h4_ff [4];
   hash_word_type    h4_in [4];
   logic [NOISE_W-1:0] c5_ff [4];
   logic [NOISE_W-1:0] c5_in [4];
   logic [FRAC_W-1:0] sx_ff [2:5];
   logic [FRAC_W-1:0] sz_ff [2:5];
   logic [FRAC_W-1:0] sx_in, sz_in;
   logic [FRAC_W-1:0] ux_in, uz_in;

   always_comb begin
      logic [W2-1:0] sqx, sqz;
      logic [W3-1:0] px, pz;
      hash_word_type mx1, mz1, h;
      sqx   = W2'(frac_x) * W2'(frac_x);
      sqz   = W2'(frac_z) * W2'(frac_z);
      ux_in = sqx[W2-1:FRAC_W];
      uz_in = sqz[W2-1:FRAC_W];
      // s = u * (3 - 2t), below one for every t below one
      px    = W3'(ux_ff) * ((W3'(3) << FRAC_W) - (W3'(tx_ff) << 1));
      pz    = W3'(uz_ff) * ((W3'(3) << FRAC_W) - (W3'(tz_ff) << 1));
      sx_in = px[W2-1:FRAC_W];
      sz_in = pz[W2-1:FRAC_W];
      // next cell along an axis adds the multiplier once more
      mx1 = mx_ff + HASH_MUL_X;
      mz1 = mz_ff + HASH_MUL_Z;
      h = key_ff ^ mx_ff ^ mz_ff;  h2_in[0] = h ^ (h >> 16);
      h = key_ff ^ mx1   ^ mz_ff;  h2_in[1] = h ^ (h >> 16);
      h = key_ff ^ mx_ff ^ mz1;    h2_in[2] = h ^ (h >> 16);
      h = key_ff ^ mx1   ^ mz1;    h2_in[3] = h ^ (h >> 16);
      for (int i = 0; i < 4; i++) begin
         h        = h3_ff[i] ^ (h3_ff[i] >> 15);
         h4_in[i] = h * HASH_MIX_B;
         h        = h4_ff[i] ^ (h4_ff[i] >> 16);
         c5_in[i] = h[NOISE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mx_ff  <= cell_x * HASH_MUL_X;
         mz_ff  <= cell_z * HASH_MUL_Z;
         key_ff <= key;
         tx_ff  <= frac_x;
         tz_ff  <= frac_z;
         ux_ff  <= ux_in;
         uz_ff  <= uz_in;
         h2_ff  <= h2_in;
         for (int i = 0; i < 4; i++) begin
            h3_ff[i] <= h2_ff[i] * HASH_MIX_A;
         end
         h4_ff  <= h4_in;
         c5_ff  <= c5_in;
         sx_ff[2] <= sx_in;
         sz_ff[2] <= sz_in;
         for (int s = 3; s <= 5; s++) begin
            sx_ff[s] <= sx_ff[s-1];
            sz_ff[s] <= sz_ff[s-1];
         end
      end
   end

   assign out_valid = vld_ff[4];
   assign corner    = c5_ff;
   assign ease_x    = sx_ff[5];
   assign ease_z    = sz_ff[5];

endmodule

@@ hw/rtl/vns_lerp.sv @@
// Bilinear blend of the four corner values, truncating; two stages.
// The second stage is the output register. Uses vns_pkg.
module vns_lerp #(
   parameter int FRAC_W = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  logic [vns_pkg::NOISE_W-1:0]   corner [4],
   input  logic [FRAC_W-1:0]             ease_x,
   input  logic [FRAC_W-1:0]             ease_z,
   output logic                          out_valid,
   output logic [vns_pkg::NOISE_W-1:0]   noise_value
);
   import vns_pkg::*;

   localparam int PW = NOISE_W + FRAC_W + 1;

   logic [1:0]         vld_ff;
   logic [NOISE_W-1:0] a_ff, b_ff, a_in, b_in, r_ff, r_in;
   logic [FRAC_W-1:0]  sz_ff;

   always_comb begin
      logic [PW-1:0] one, sum;
      one  = PW'(1) << FRAC_W;
      sum  = PW'(corner[0]) * (one - PW'(ease_x)) + PW'(corner[1]) * PW'(ease_x);
      a_in = sum[NOISE_W+FRAC_W-1:FRAC_W];
      sum  = PW'(corner[2]) * (one - PW'(ease_x)) + PW'(corner[3]) * PW'(ease_x);
      b_in = sum[NOISE_W+FRAC_W-1:FRAC_W];
      sum  = PW'(a_ff) * (one - PW'(sz_ff)) + PW'(b_ff) * PW'(sz_ff);
      r_in = sum[NOISE_W+FRAC_W-1:FRAC_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_ff  <= a_in;
         b_ff  <= b_in;
         sz_ff <= ease_z;
         r_ff  <= r_in;
      end
   end

   assign out_valid   = vld_ff[1];
   assign noise_value = r_ff;

endmodule

@@ hw/rtl/value_noise_2d_sampler.sv @@
// Top level of the 2D value-noise sampler: seed register and pipeline glue.
// Depends on vns_pkg, vns_split, vns_hash and vns_lerp.
//
//   channel  direction  handshake            beat carries
//   req      in         req_valid/req_ready  coord_x, coord_z, period, salt
//   rsp      out        rsp_valid/rsp_ready  noise_value
//   csr      in         csr_write_en         seed (32 bit, no read-back)
//
// One beat in and one beat out per cycle when not stalled.
// The floor divider resolves four quotient bits per stage.
// Synchronous active-high reset clears the seed and all valid bits.
// A stall on rsp freezes the whole pipeline; req_ready drops in the same cycle.
module value_noise_2d_sampler #(
   parameter int MAX_PERIOD    = vns_pkg::DEF_MAX_PERIOD,
   parameter int FRACTION_BITS = vns_pkg::DEF_FRACTION_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [vns_pkg::COORD_W-1:0] req_coord_x,
   input  logic signed [vns_pkg::COORD_W-1:0] req_coord_z,
   input  logic [vns_pkg::PERIOD_W-1:0]       req_period,
   input  logic [31:0]                        req_salt,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [vns_pkg::NOISE_W-1:0]        rsp_noise_value,
   input  logic                               csr_write_en,
   input  logic [31:0]                        csr_write_data
);
   import vns_pkg::*;

   hash_word_type seed_ff;
   logic          adv;

   logic              sp_valid;
   hash_word_type     sp_cell_x, sp_cell_z, sp_key;
   logic [FRACTION_BITS-1:0] sp_frac_x, sp_frac_z;

   logic              hs_valid;
   logic [NOISE_W-1:0] hs_corner [4];
   logic [FRACTION_BITS-1:0] hs_ease_x, hs_ease_z;

   // every stage moves together unless a finished result is held
   assign adv       = ~rsp_valid | rsp_ready;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
      end else if (csr_write_en) begin
         seed_ff <= csr_write_data;
      end
   end

   // key is captured with the beat, so a later seed write cannot touch it
   vns_split #(
      .MAX_PERIOD (MAX_PERIOD),
      .FRAC_W     (FRACTION_BITS)
   ) u_split (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid & req_ready),
      .coord_x   (req_coord_x),
      .coord_z   (req_coord_z),
      .period    (req_period),
      .key       (seed_ff ^ req_salt),
      .out_valid (sp_valid),
      .cell_x    (sp_cell_x),
      .cell_z    (sp_cell_z),
      .frac_x    (sp_frac_x),
      .frac_z    (sp_frac_z),
      .out_key   (sp_key)
   );

   vns_hash #(
      .FRAC_W (FRACTION_BITS)
   ) u_hash (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (sp_valid),
      .cell_x    (sp_cell_x),
      .cell_z    (sp_cell_z),
      .frac_x    (sp_frac_x),
      .frac_z    (sp_frac_z),
      .key       (sp_key),
      .out_valid (hs_valid),
      .corner    (hs_corner),
      .ease_x    (hs_ease_x),
      .ease_z    (hs_ease_z)
   );

   vns_lerp #(
      .FRAC_W (FRACTION_BITS)
   ) u_lerp (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (hs_valid),
      .corner      (hs_corner),
      .ease_x      (hs_ease_x),
      .ease_z      (hs_ease_z),
      .out_valid   (rsp_valid),
      .noise_value (rsp_noise_value)
   );

`ifndef SYNTHESIS
   // nothing survives reset
   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid straight after reset");

   // an empty output stage must never block the input
   a_no_false_stall : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output stage");

   // seed takes the written value on the next edge
   a_seed_write : assert property (@(posedge clock) disable iff (reset)
      csr_write_en |=> seed_ff == $past(csr_write_data))
      else $error("seed register missed a write");
`endif

endmodule

@@ sim/tb_top.sv @@
// Self-checking bench for value_noise_2d_sampler: random and directed samples
// checked against an in-bench predictor. Depends on vns_pkg and the block's RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import vns_pkg::*;

   localparam int LATENCY  = 20;
   localparam int WD_LIMIT = 20000;
   localparam int FB       = DEF_FRACTION_BITS;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [COORD_W-1:0] req_coord_x = '0;
   logic signed [COORD_W-1:0] req_coord_z = '0;
   logic [PERIOD_W-1:0] req_period = '0;
   logic [31:0] req_salt = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [NOISE_W-1:0] rsp_noise_value;
   logic csr_write_en = 1'b0;
   logic [31:0] csr_write_data = '0;

   value_noise_2d_sampler dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_coord_x(req_coord_x), .req_coord_z(req_coord_z),
      .req_period(req_period), .req_salt(req_salt),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_noise_value(rsp_noise_value),
      .csr_write_en(csr_write_en), .csr_write_data(csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // bench copy of the seed register and the queue of predicted noise values
   logic [31:0] seed_shadow = '0;
   logic [NOISE_W-1:0] noise_due[$];
   int mismatches = 0;
   int idle_cycles = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit recv_hold = 1'b0;

   task automatic report_mismatch(input string what);
      $display("mismatch: %s", what);
      mismatches++;
   endtask

   function automatic logic [15:0] corner_value(input logic [31:0] cx, input logic [31:0] cz,
                                                input logic [31:0] key);
      logic [31:0] h;
      h = key;
      h ^= cx * HASH_MUL_X;
      h ^= cz * HASH_MUL_Z;
      h ^= h >> 16;
      h *= HASH_MIX_A;
      h ^= h >> 15;
      h *= HASH_MIX_B;
      h ^= h >> 16;
      return h[15:0];
   endfunction

   // smoothstep of the offset within its cell, Q0.F
   function automatic longint unsigned eased(input longint unsigned off,
                                              input longint unsigned p);
      longint unsigned t, u;
      t = (off << FB) / p;
      u = (t * t) >> FB;
      return (u * ((3 << FB) - 2 * t)) >> FB;
   endfunction

   function automatic longint unsigned blend(input longint unsigned c0,
                                              input longint unsigned c1,
                                              input longint unsigned s);
      return (c0 * ((64'd1 << FB) - s) + c1 * s) >> FB;
   endfunction

   function automatic logic [15:0] predict_noise(input logic signed [31:0] x,
                                                 input logic signed [31:0] z,
                                                 input logic [8:0] per,
                                                 input logic [31:0] salt);
      longint p, gx, gz, xx, zz;
      longint unsigned sx, sz, a, b;
      logic [31:0] x0, z0, key;
      p = per;
      if (p == 0) p = 1;
      if (p > DEF_MAX_PERIOD) p = DEF_MAX_PERIOD;
      xx = x;
      zz = z;
      gx = xx / p;
      if (xx % p != 0 && xx < 0) gx--;
      gz = zz / p;
      if (zz % p != 0 && zz < 0) gz--;
      sx = eased(xx - gx * p, p);
      sz = eased(zz - gz * p, p);
      x0 = gx[31:0];
      z0 = gz[31:0];
      key = seed_shadow ^ salt;
      a = blend(corner_value(x0, z0, key), corner_value(x0 + 1, z0, key), sx);
      b = blend(corner_value(x0, z0 + 1, key), corner_value(x0 + 1, z0 + 1, key), sx);
      return 16'(blend(a, b, sz));
   endfunction

   // one beat on req; expectation queued at acceptance; valid stays up for the next beat
   task automatic send_sample(input logic signed [31:0] x, input logic signed [31:0] z,
                              input logic [8:0] per, input logic [31:0] salt);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_coord_x <= x;
      req_coord_z <= z;
      req_period <= per;
      req_salt <= salt;
      do @(posedge clock); while (!req_ready);
      noise_due.push_back(predict_noise(x, z, per, salt));
   endtask

   // seed only changes once the pipe has drained
   task automatic write_seed(input logic [31:0] v);
      req_valid <= 1'b0;
      while (noise_due.size() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_en <= 1'b0;
      seed_shadow = v;
   endtask

   // receiver: random stalls, or a long hold while recv_hold is set
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // checker: every accepted result against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (noise_due.size() == 0) begin
            report_mismatch("result beat with nothing expected");
         end else begin
            logic [15:0] want;
            want = noise_due.pop_front();
            if (rsp_noise_value !== want)
               report_mismatch($sformatf("noise_value got %h want %h", rsp_noise_value, want));
         end
      end
   end

   // watchdog: cycles with no beat on either channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else if (++idle_cycles >= WD_LIMIT) begin
         $display("[value_noise_2d_sampler] ERROR");
         $finish;
      end
   end

   task automatic test_field_extremes();
      send_sample(32'sh7fffffff, 32'sh80000000, 9'd256, 32'h0);
      send_sample(32'sh80000000, 32'sh7fffffff, 9'd1, 32'hffffffff);
      send_sample(0, 0, 9'd3, 32'h1234);
      send_sample(-1, -1, 9'd256, 32'h5555aaaa);
      send_sample(255, -256, 9'd256, 32'haaaa5555);
      send_sample(32'sh7fffffff, 32'sh7fffffff, 9'd1, 32'h1);
      send_sample(-7, 7, 9'd5, 32'h0);
   endtask

   task automatic test_period_corner_cases();
      send_sample(12345, -54321, 9'd0, 32'hdead);    // zero period acts as one
      send_sample(1000, -1000, 9'd257, 32'hbeef);    // saturates to the maximum
      send_sample(-1000, 1000, 9'd511, 32'hbeef);
      send_sample(32'sh7fffff80, 32'sh7fffffff, 9'd300, 32'h7); // 300 also saturates to the maximum
      send_sample(1, 2, 9'd2, 32'h0);
   endtask

   task automatic test_random_samples(input int n);
      logic signed [31:0] x, z;
      logic [8:0] per;
      repeat (n) begin
         x = $urandom;
         z = $urandom;
         if ($urandom_range(3) == 0) begin
            x = $signed($urandom_range(2000)) - 1000;
            z = $signed($urandom_range(2000)) - 1000;
         end
         per = ($urandom_range(9) == 0) ? 9'($urandom) : 9'($urandom_range(256, 1));
         send_sample(x, z, per, $urandom);
      end
   endtask

   // receiver holds off long enough for the pipe to fill and req_ready to fall
   task automatic test_backpressure();
      recv_hold = 1'b1;
      fork
         test_random_samples(40);
         begin
            repeat (150) @(posedge clock);
            recv_hold = 1'b0;
         end
      join
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_field_extremes();
      test_period_corner_cases();
      write_seed(32'hffffffff);
      test_field_extremes();
      write_seed(32'h0);
      send_idle_pct = 11;
      recv_idle_pct = 81;
      test_random_samples(500);
      write_seed($urandom);
      send_idle_pct = 81;
      recv_idle_pct = 11;
      test_random_samples(500);
      test_backpressure();
      write_seed($urandom);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_samples(580);
      req_valid <= 1'b0;
      while (noise_due.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
      if (mismatches == 0) begin
         $display("[value_noise_2d_sampler] OK");
      end else begin
         $display("[value_noise_2d_sampler] ERROR");
      end
      $finish;
   end
endmodule
